/* rtl/tpcp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpcp_pkg
// Shared constants, codes and types of the ternary prefix code packer.
// ----------------------------------------------------------------------------
package tpcp_pkg;

  localparam int MAX_TRITS    = 32;
  localparam int SYMBOL_COUNT = 256;

  localparam int SYM_W  = 8;
  localparam int IDX_W  = $clog2(SYMBOL_COUNT);
  localparam int LEN_W  = 6;
  localparam int CODE_W = 64;
  localparam int BYTE_W = 8;
  localparam int FILL_W = 3;
  localparam int SH_W   = $clog2(CODE_W + 1);

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // Work handed from the front to the back
  typedef struct packed {
    logic              is_flush;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] trits;
  } cmd_t;

  // Back status, watched at the top level
  typedef struct packed {
    logic              busy;
    logic [FILL_W-1:0] pending_bits;
  } back_stat_t;

endpackage
`default_nettype wire

/* rtl/tpcp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpcp_in_if / tpcp_out_if
// Valid/ready channels carrying input items and packed output bytes.
// ----------------------------------------------------------------------------
interface tpcp_in_if import tpcp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [SYM_W-1:0]  symbol;
  logic [LEN_W-1:0]  code_length;
  logic [CODE_W-1:0] code_trits;

  modport source (output valid, op, symbol, code_length, code_trits, input ready);
  modport sink   (input valid, op, symbol, code_length, code_trits, output ready);
endinterface

interface tpcp_out_if import tpcp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] packed_byte;
  logic              last_of_run;

  modport source (output valid, packed_byte, last_of_run, input ready);
  modport sink   (input valid, packed_byte, last_of_run, output ready);
endinterface
`default_nettype wire

/* rtl/tpcp_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpcp_front
// Accepts items, keeps the code table, looks up encodes and issues work.
// ----------------------------------------------------------------------------
module tpcp_front import tpcp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tpcp_in_if.sink   in_ch,
  output logic      push_valid,
  input  logic      push_ready,
  output cmd_t      push_cmd
);

  logic [LEN_W-1:0]        len_mem  [SYMBOL_COUNT];
  logic [CODE_W-1:0]       trit_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] len_valid_r;

  logic              s1_valid_r;
  logic              s1_flush_r;
  logic              rd_valid_r;
  logic [LEN_W-1:0]  rd_len_r;
  logic [CODE_W-1:0] rd_trits_r;

  logic             accept;
  logic             sym_ok;
  logic             is_load;
  logic             is_encode;
  logic             is_flush;
  logic             s1_adv;
  logic [IDX_W-1:0] idx;
  logic [LEN_W-1:0] len_sat;
  logic [LEN_W-1:0] eff_len;

  always_comb begin
    is_load   = 1'b0;
    is_encode = 1'b0;
    is_flush  = 1'b0;
    unique case (in_ch.op)
      OP_LOAD:   is_load   = 1'b1;
      OP_ENCODE: is_encode = 1'b1;
      OP_FLUSH:  is_flush  = 1'b1;
      default: ;
    endcase
  end

  assign idx     = in_ch.symbol[IDX_W-1:0];
  assign sym_ok  = ({1'b0, in_ch.symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
  assign len_sat = (in_ch.code_length > LEN_W'(MAX_TRITS)) ? LEN_W'(MAX_TRITS)
                                                           : in_ch.code_length;

  // An entry never loaded reads as length zero
  assign eff_len    = rd_valid_r ? rd_len_r : '0;
  // Drop encodes of unused symbols here
  assign push_valid = s1_valid_r && (s1_flush_r || (eff_len != '0));
  assign s1_adv     = !push_valid || push_ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign accept     = in_ch.valid && in_ch.ready;

  assign push_cmd.is_flush = s1_flush_r;
  assign push_cmd.len      = eff_len;
  assign push_cmd.trits    = rd_trits_r;

  always_ff @(posedge clk) begin
    if (accept && is_load && sym_ok) begin
      len_mem[idx]  <= len_sat;
      trit_mem[idx] <= in_ch.code_trits;
    end
    if (accept && is_encode) begin
      rd_len_r   <= len_mem[idx];
      rd_trits_r <= trit_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_valid_r <= '0;
      s1_valid_r  <= 1'b0;
      s1_flush_r  <= 1'b0;
      rd_valid_r  <= 1'b0;
    end else begin
      if (accept && is_load && sym_ok) begin
        len_valid_r[idx] <= 1'b1;
      end
      if (accept && is_encode) begin
        rd_valid_r <= len_valid_r[idx];
      end
      if (s1_adv) begin
        s1_valid_r <= accept && (is_flush || (is_encode && sym_ok));
        s1_flush_r <= is_flush;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/tpcp_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpcp_queue
// Short first-in first-out queue of work between the front and the back.
// ----------------------------------------------------------------------------
module tpcp_queue import tpcp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W:0]   count_r;
  logic [Q_PTR_W:0]   count_nxt;
  logic               push;
  logic               pop;

  assign push_ready = (count_r != (Q_PTR_W + 1)'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/tpcp_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpcp_back
// Packs trits into bytes, one per cycle when not stalled, and handles flushes.
// ----------------------------------------------------------------------------
module tpcp_back import tpcp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  cmd_t        pop_cmd,
  tpcp_out_if.source  out_ch,
  output back_stat_t  stat
);

  logic              busy_r,      busy_nxt;
  logic              flush_r;
  logic [LEN_W-1:0]  rem_r,       rem_nxt;
  logic [CODE_W-1:0] trits_r,     trits_nxt;
  logic [BYTE_W-1:0] pend_byte_r, pend_byte_nxt;
  logic [FILL_W-1:0] pend_bits_r, pend_bits_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r,  out_byte_nxt;
  logic              out_last_r,  out_last_nxt;

  logic              out_free;
  logic              step_en;
  logic              step_done;
  logic              pop;
  logic              full;
  logic [2:0]        need;
  logic [2:0]        take;
  logic [BYTE_W-1:0] stream;
  logic [BYTE_W-1:0] mask;
  logic [BYTE_W-1:0] merged;
  logic [LEN_W-1:0]  rem_after;
  logic [SH_W-1:0]   align_sh;

  assign out_free = !out_valid_r || out_ch.ready;
  assign step_en  = busy_r && out_free;

  // Trits still wanted to complete the pending byte: one to four
  assign need = 3'((4'd8 - {1'b0, pend_bits_r}) >> 1);
  assign full = (rem_r >= LEN_W'(need));
  assign take = full ? need : rem_r[2:0];
  assign rem_after = rem_r - LEN_W'(take);

  // Next four trits, first sent in the low bits, low bit of each trit first
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      stream[2*i +: 2] = trits_r[CODE_W-1-2*i -: 2];
    end
  end

  assign mask   = BYTE_W'((9'd1 << {take, 1'b0}) - 9'd1);
  assign merged = pend_byte_r | BYTE_W'({8'h00, stream & mask} << pend_bits_r);

  assign step_done = flush_r || !full || (rem_after == '0);
  assign pop_ready = !busy_r || (step_en && step_done);
  assign pop       = pop_valid && pop_ready;
  // Left-align the code so its top trit sits in the top two bits
  assign align_sh  = SH_W'(CODE_W) - SH_W'({pop_cmd.len, 1'b0});

  always_comb begin
    busy_nxt      = busy_r;
    rem_nxt       = rem_r;
    trits_nxt     = trits_r;
    pend_byte_nxt = pend_byte_r;
    pend_bits_nxt = pend_bits_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;

    if (step_en) begin
      if (flush_r) begin
        if (pend_bits_r != '0) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = pend_byte_r;
          out_last_nxt  = 1'b1;
        end
        pend_byte_nxt = '0;
        pend_bits_nxt = '0;
      end else if (full) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = merged;
        // Fewer than four trits left cannot fill another byte
        out_last_nxt  = (rem_after < LEN_W'(4));
        pend_byte_nxt = '0;
        pend_bits_nxt = '0;
      end else begin
        pend_byte_nxt = merged;
        pend_bits_nxt = pend_bits_r + FILL_W'({take, 1'b0});
      end
      rem_nxt   = rem_after;
      trits_nxt = trits_r << {take, 1'b0};
      busy_nxt  = !step_done;
    end

    if (pop) begin
      busy_nxt  = 1'b1;
      rem_nxt   = pop_cmd.len;
      trits_nxt = pop_cmd.trits << align_sh;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    trits_r    <= trits_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    if (pop) begin
      flush_r <= pop_cmd.is_flush;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pend_byte_r <= '0;
      pend_bits_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pend_byte_r <= pend_byte_nxt;
      pend_bits_r <= pend_bits_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.packed_byte = out_byte_r;
  assign out_ch.last_of_run = out_last_r;

  assign stat.busy         = busy_r;
  assign stat.pending_bits = pend_bits_r;

endmodule
`default_nettype wire

/* rtl/ternary_prefix_code_packer_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ternary_prefix_code_packer_top
// Packs ternary prefix codes, two bits per trit, into a stream of bytes.
// ----------------------------------------------------------------------------
//  Channel  Dir  Carries                                   Accepted when
//  in_ch    in   op, symbol, code_length, code_trits       valid && ready
//  out_ch   out  packed_byte, last_of_run                  valid && ready
//
//  A load item writes the code table in the front. An encode item is read
//  from the table in the front, then the back packs it one step at a time,
//  each step emitting one output byte (up to eight) or stowing trailing
//  trits in the pending byte.
//  Reset: synchronous, active low; clears the table's valid bits, the queue,
//  the pending byte and the output valid bit. No clearing pass is needed.
//  Stalls: a stalled output holds the back; the two-entry queue lets the
//  front keep taking items until it fills.
// ----------------------------------------------------------------------------
module ternary_prefix_code_packer_top import tpcp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tpcp_in_if.sink    in_ch,
  tpcp_out_if.source out_ch
);

  // Front to queue
  logic       q_push_valid;
  logic       q_push_ready;
  cmd_t       q_push_cmd;
  // Queue to back
  logic       q_pop_valid;
  logic       q_pop_ready;
  cmd_t       q_pop_cmd;
  back_stat_t back_stat;

  // Accept, classify and look up the code
  tpcp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_cmd   (q_push_cmd)
  );

  // Decouple lookup from packing
  tpcp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_cmd   (q_push_cmd),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_cmd    (q_pop_cmd)
  );

  // Pack trits and emit bytes
  tpcp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_cmd   (q_pop_cmd),
    .out_ch    (out_ch),
    .stat      (back_stat)
  );

  // A full queue must hold work for the back
  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !q_push_ready |-> q_pop_valid)
    else $error("queue reports full while empty");

  // Trits arrive in pairs of bits, so the fill stays even
  a_pending_even: assert property (@(posedge clk) disable iff (!rst_n)
    !back_stat.pending_bits[0])
    else $error("odd pending bit count");

  // Nothing is offered in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid && !q_pop_valid && !back_stat.busy)
    else $error("activity straight after reset");

endmodule
`default_nettype wire
